### rtl/core/pidf_pkg.sv
`timescale 1ns / 1ps
package pidf_pkg;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
    logic        [16:0] interval_us;
  } pidf_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               in_dead_band;
  } pidf_out_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_SEP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd7;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [16:0] DT_MAX    = 17'd100000;
  localparam logic [19:0] RATE_SCALE = 20'd1000000;
  // quotient bits: |delta*1e6| < 2^36, so 36 steps cover the 36-bit dividend
  localparam int DIV_STEPS = 36;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FILT_A,
    ST_FILT_B,
    ST_INTEG,
    ST_TERM_P,
    ST_TERM_IH,
    ST_TERM_IL,
    ST_TERM_D,
    ST_DONE,
    ST_OUT
  } pidf_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic filt_a;
    logic filt_b;
    logic integ;
    logic term_p;
    logic term_ih;
    logic term_il;
    logic term_d;
    logic finish;
  } pidf_cmd_t;

  typedef struct packed {
    logic dead;
    logic div_last;
  } pidf_sts_t;

endpackage

### rtl/core/pid_controller_filtered_top.sv
`timescale 1ns / 1ps
// Timing: outside the dead band each item runs through the 36-step restoring
// divider for the rate term; inside it the controller goes from PREP to OUT.
// Throughput: one item at a time; a new input is taken only after the result
// has been accepted with out_stall low.
// Reset: synchronous active-low rst_n clears the FSM, the controller state and
// the config registers, not the item registers; alpha resets to 65536 (no filtering).
module pid_controller_filtered_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [pidf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  pidf_pkg::pidf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pidf_pkg::pidf_out_t out_data
);
  import pidf_pkg::*;

  pidf_cmd_t cmd;
  pidf_sts_t sts;

  pidf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  pidf_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_data, .out_data, .cmd, .sts
  );

endmodule

### rtl/core/pidf_ctrl.sv
`timescale 1ns / 1ps
module pidf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pidf_pkg::pidf_sts_t sts,
  output pidf_pkg::pidf_cmd_t cmd
);
  import pidf_pkg::*;

  pidf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_PREP;
      ST_PREP:    state_nxt = sts.dead ? ST_OUT : ST_DIV;
      ST_DIV:     if (sts.div_last) state_nxt = ST_FILT_A;
      ST_FILT_A:  state_nxt = ST_FILT_B;
      ST_FILT_B:  state_nxt = ST_INTEG;
      ST_INTEG:   state_nxt = ST_TERM_P;
      ST_TERM_P:  state_nxt = ST_TERM_IH;
      ST_TERM_IH: state_nxt = ST_TERM_IL;
      ST_TERM_IL: state_nxt = ST_TERM_D;
      ST_TERM_D:  state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_OUT;
      ST_OUT:     if (!out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PREP:    cmd.prep = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_FILT_A:  cmd.filt_a = 1'b1;
      ST_FILT_B:  cmd.filt_b = 1'b1;
      ST_INTEG:   cmd.integ = 1'b1;
      ST_TERM_P:  cmd.term_p = 1'b1;
      ST_TERM_IH: cmd.term_ih = 1'b1;
      ST_TERM_IL: cmd.term_il = 1'b1;
      ST_TERM_D:  cmd.term_d = 1'b1;
      ST_DONE:    cmd.finish = 1'b1;
      ST_OUT:     out_valid = 1'b1;
      default:    ;
    endcase
  end

endmodule

### rtl/core/pidf_datapath.sv
`timescale 1ns / 1ps
module pidf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [pidf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  pidf_pkg::pidf_in_t  in_data,
  output pidf_pkg::pidf_out_t out_data,
  input  pidf_pkg::pidf_cmd_t cmd,
  output pidf_pkg::pidf_sts_t sts
);
  import pidf_pkg::*;

  // configuration
  logic signed [31:0] kp_r, ki_r, kd_r;
  logic        [16:0] alpha_r;
  logic        [46:0] ilim_r;
  logic        [30:0] dlim_r;
  logic        [15:0] isep_r, dband_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0; ki_r <= '0; kd_r <= '0;
      alpha_r <= ALPHA_ONE;
      ilim_r <= '0; dlim_r <= '0; isep_r <= '0; dband_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:   kp_r    <= cfg_data[31:0];
        REG_GAIN_INTEG:  ki_r    <= cfg_data[31:0];
        REG_GAIN_DERIV:  kd_r    <= cfg_data[31:0];
        REG_ALPHA:       alpha_r <= cfg_data[16:0];
        REG_INTEG_LIMIT: ilim_r  <= cfg_data[46:0];
        REG_DRIVE_LIMIT: dlim_r  <= cfg_data[30:0];
        REG_INTEG_SEP:   isep_r  <= cfg_data[15:0];
        REG_DEAD_BAND:   dband_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // controller state
  logic signed [15:0] prev_meas_r;
  logic signed [31:0] prev_filt_r;
  logic signed [47:0] integ_r;

  // item registers
  logic signed [15:0] meas_r;
  logic signed [16:0] err_r;
  logic        [16:0] dt_r;
  logic        [16:0] abs_err_r;
  logic               neg_r;
  logic        [35:0] dvd_r;   // dividend magnitude, shifted out MSB first
  logic        [36:0] quo_r;
  logic        [16:0] rem_r;
  logic        [5:0]  cnt_r;
  logic signed [48:0] fa_r;
  logic signed [47:0] integ_new_r;
  logic signed [63:0] acc_r;
  logic               dead_r;
  logic signed [31:0] drive_r;

  // combinational helpers
  logic signed [16:0] sp_ext, ms_ext, err_c;
  logic        [16:0] abs_c;
  logic        [16:0] dt_c;
  logic               dead_c;
  logic signed [16:0] delta_c;
  logic        [16:0] dmag_c;
  logic        [35:0] dvd_c;
  logic        [17:0] rem_sh;
  logic        [17:0] rem_sub;
  logic signed [37:0] qs;
  logic signed [31:0] rate_c;
  logic        [16:0] alpha_c;
  logic signed [48:0] fa_c;
  logic signed [48:0] fb_prod;
  logic signed [49:0] fb;
  logic signed [31:0] filt_c;
  logic signed [34:0] ierr_prod;
  logic signed [48:0] isum;
  logic signed [48:0] ilim_s;
  logic signed [47:0] iclamp;
  logic signed [47:0] ival;
  logic signed [23:0] ihi;
  logic        [23:0] ilo;
  logic signed [56:0] p_ih;
  logic signed [56:0] p_il;
  logic signed [48:0] p_p;
  logic signed [63:0] dsum;
  logic signed [63:0] dlim_s;

  always_comb begin
    sp_ext  = 17'(in_data.setpoint);
    ms_ext  = 17'(in_data.measured);
    err_c   = sp_ext - ms_ext;
    abs_c   = err_c[16] ? 17'(-err_c) : err_c;
    if (in_data.interval_us == '0) dt_c = 17'd1;
    else if (in_data.interval_us > DT_MAX) dt_c = DT_MAX;
    else dt_c = in_data.interval_us;
    dead_c  = (abs_c < {1'b0, dband_r});
    delta_c = 17'(meas_r) - 17'(prev_meas_r);
    dmag_c  = delta_c[16] ? 17'(-delta_c) : delta_c;
    dvd_c   = dmag_c * RATE_SCALE;
    rem_sh  = {rem_r, dvd_r[35]};
    rem_sub = rem_sh - {1'b0, dt_r};
    qs      = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    if (qs > 38'sd2147483647) rate_c = 32'h7fffffff;
    else if (qs < -38'sd2147483648) rate_c = 32'h80000000;
    else rate_c = qs[31:0];
    alpha_c = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    fa_c    = $signed({1'b0, alpha_c}) * rate_c;
    fb_prod = $signed({1'b0, 17'(ALPHA_ONE - alpha_c)}) * prev_filt_r;
    fb      = 50'(fa_r) + 50'(fb_prod);
    filt_c  = fb[47:16];
    ierr_prod = err_r * $signed({1'b0, dt_r});
    isum    = 49'(integ_r) + 49'(ierr_prod);
    ilim_s  = $signed({2'b00, ilim_r});
    if (isum > ilim_s) iclamp = ilim_s[47:0];
    else if (isum < -ilim_s) iclamp = 48'(-ilim_s);
    else iclamp = isum[47:0];
    if (isep_r != '0 && abs_err_r > {1'b0, isep_r}) ival = '0;
    else ival = iclamp;
    ihi     = integ_new_r[47:24];
    ilo     = integ_new_r[23:0];
    p_p     = kp_r * err_r;
    p_ih    = ki_r * ihi;
    p_il    = ki_r * $signed({1'b0, ilo});
    dsum    = acc_r;
    dlim_s  = $signed({33'd0, dlim_r});
  end

  // integral term = floor((ki*hi + floor(ki*lo/2^24)) / 2^12); mid_r holds ki*hi, mid_sum that sum
  logic signed [63:0] mid_r;
  logic signed [63:0] kd_prod;
  logic signed [63:0] mid_sum;
  assign kd_prod = kd_r * prev_filt_r;
  assign mid_sum = mid_r + 64'(p_il >>> 24);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_r    <= in_data.measured;
      err_r     <= err_c;
      abs_err_r <= abs_c;
      dt_r      <= dt_c;
      dead_r    <= dead_c;
    end
    if (cmd.prep) begin
      neg_r <= ~delta_c[16] && (delta_c != '0);
      dvd_r <= dvd_c;
      quo_r <= '0;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (!rem_sub[17]) begin
        rem_r <= rem_sub[16:0];
        quo_r <= {quo_r[35:0], 1'b1};
      end else begin
        rem_r <= rem_sh[16:0];
        quo_r <= {quo_r[35:0], 1'b0};
      end
      dvd_r <= {dvd_r[34:0], 1'b0};
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.filt_a) fa_r <= fa_c;
    if (cmd.integ) integ_new_r <= ival;
    if (cmd.term_p) acc_r <= 64'(p_p >>> 16);
    if (cmd.term_ih) mid_r <= 64'(p_ih);
    if (cmd.term_il) acc_r <= acc_r + (mid_sum >>> 12);
    // prev_filt_r already holds this item's filtered rate here
    if (cmd.term_d) acc_r <= acc_r + (kd_prod >>> 16);
    if (cmd.finish) begin
      if (dsum > dlim_s) drive_r <= dlim_s[31:0];
      else if (dsum < -dlim_s) drive_r <= 32'(-dlim_s);
      else drive_r <= dsum[31:0];
    end
  end

  // state commits only for items outside the dead band
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_meas_r <= '0;
      prev_filt_r <= '0;
      integ_r     <= '0;
    end else begin
      if (cmd.filt_a) prev_meas_r <= meas_r;
      if (cmd.filt_b) prev_filt_r <= filt_c;
      if (cmd.integ)  integ_r     <= ival;
    end
  end

  assign sts.dead     = dead_r;
  assign sts.div_last = (cnt_r == 6'(DIV_STEPS - 1));
  assign out_data.drive        = dead_r ? 32'sd0 : drive_r;
  assign out_data.in_dead_band = dead_r;

endmodule

### rtl/core/pidf_checker.sv
`timescale 1ns / 1ps
module pidf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pidf_pkg::pidf_out_t out_data
);
  import pidf_pkg::*;

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_dead_band |-> out_data.drive == '0)
    else $error("dead band result not zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

endmodule

bind pid_controller_filtered_top pidf_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
